/* design/rgbmm_pkg.sv */
// Shared types and constants for the RGB min-max contrast stretch block.
// Used by the front, queue, back and top-level modules; no dependencies.
package rgbmm_pkg;

  typedef logic [7:0] pix_t;

  // Item kind carried in tuser bit 0
  typedef enum logic {
    CMD_MEASURE = 1'b0,
    CMD_APPLY   = 1'b1
  } cmd_t;

  // One channel's division job: offset above low and span, or a bypass value
  typedef struct packed {
    logic bypass;
    pix_t d;
    pix_t span;
  } chan_job_t;

  typedef struct packed {
    chan_job_t blue;
    chan_job_t green;
    chan_job_t red;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bk_stat_t;

  // Quotient never exceeds 255, so eight restoring steps suffice
  localparam int unsigned DivSteps = 8;
  localparam logic [2:0] LastStep = 3'(DivSteps - 1);

endpackage

/* design/rgbmm_front.sv */
// Front end: accepts pixels, tracks per-channel min/max on measure items and
// turns apply items into division jobs. Depends on rgbmm_pkg.
module rgbmm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic             in_start,
  input  logic [23:0]      in_pix,
  input  rgbmm_pkg::q_stat_t q_stat,
  output logic             push,
  output rgbmm_pkg::job_t  job
);
  import rgbmm_pkg::*;

  pix_t red_low, red_high, green_low, green_high, blue_low, blue_high;
  pix_t red_low_next, red_high_next, green_low_next, green_high_next;
  pix_t blue_low_next, blue_high_next;
  pix_t red_v, green_v, blue_v;
  logic accept;

  // Update one channel's statistics
  function automatic logic [15:0] track(pix_t v, logic restart, pix_t lo, pix_t hi);
    pix_t lo_n;
    pix_t hi_n;
    lo_n = lo;
    hi_n = hi;
    if (restart) begin
      lo_n = v;
      hi_n = v;
    end else begin
      if (v < lo) lo_n = v;
      if (v > hi) hi_n = v;
    end
    return {lo_n, hi_n};
  endfunction

  // Clamp to the measured range and form the division operands
  function automatic chan_job_t make_chan(pix_t v, pix_t lo, pix_t hi);
    chan_job_t j;
    pix_t x;
    x = v;
    if (hi <= lo) begin
      j.bypass = 1'b1;
      j.d      = v;
      j.span   = '0;
    end else begin
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      j.bypass = 1'b0;
      j.d      = x - lo;
      j.span   = hi - lo;
    end
    return j;
  endfunction

  assign red_v    = in_pix[7:0];
  assign green_v  = in_pix[15:8];
  assign blue_v   = in_pix[23:16];
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Classify: apply items go to the queue, measure items stay here
  assign push = accept && (cmd_t'(in_cmd) == CMD_APPLY);
  always_comb begin
    job.red   = make_chan(red_v, red_low, red_high);
    job.green = make_chan(green_v, green_low, green_high);
    job.blue  = make_chan(blue_v, blue_low, blue_high);
  end

  // Next statistics for a measure item
  always_comb begin
    {red_low_next, red_high_next}     = track(red_v, in_start, red_low, red_high);
    {green_low_next, green_high_next} = track(green_v, in_start, green_low, green_high);
    {blue_low_next, blue_high_next}   = track(blue_v, in_start, blue_low, blue_high);
  end

  // Hold statistics, advance on an accepted measure item
  always_ff @(posedge clk) begin
    if (rst) begin
      red_low    <= 8'd255;
      red_high   <= 8'd0;
      green_low  <= 8'd255;
      green_high <= 8'd0;
      blue_low   <= 8'd255;
      blue_high  <= 8'd0;
    end else if (accept && (cmd_t'(in_cmd) == CMD_MEASURE)) begin
      red_low    <= red_low_next;
      red_high   <= red_high_next;
      green_low  <= green_low_next;
      green_high <= green_high_next;
      blue_low   <= blue_low_next;
      blue_high  <= blue_high_next;
    end
  end

endmodule

/* design/rgbmm_queue.sv */
// Short job queue between front and back, register based.
// Depends on rgbmm_pkg for the job and status types.
module rgbmm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rgbmm_pkg::job_t    push_job,
  input  logic               pop,
  output rgbmm_pkg::job_t    pop_job,
  output rgbmm_pkg::q_stat_t stat
);
  import rgbmm_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CntW'(DEPTH));
  assign pop_job    = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* design/rgbmm_back.sv */
// Back end: three restoring dividers, one quotient bit per cycle, and the
// output register. Depends on rgbmm_pkg.
module rgbmm_back (
  input  logic               clk,
  input  logic               rst,
  input  rgbmm_pkg::q_stat_t q_stat,
  input  rgbmm_pkg::job_t    q_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_pix,
  output rgbmm_pkg::bk_stat_t stat
);
  import rgbmm_pkg::*;

  bk_state_t       state, state_next;
  logic [2:0]      step;
  chan_job_t [2:0] cur;
  chan_job_t [2:0] jobs;
  pix_t            rem   [3];
  pix_t            low   [3];
  logic [8:0]      trial [3];
  logic            ge    [3];
  logic [15:0]     num   [3];
  pix_t            res   [3];
  logic            out_load;

  assign jobs = {q_job.blue, q_job.green, q_job.red};

  // One restoring step per channel, plus load value 255*d and final result
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem[c], low[c][7]};
      ge[c]    = trial[c] >= {1'b0, cur[c].span};
      num[c]   = {jobs[c].d, 8'd0} - {8'd0, jobs[c].d};
      res[c]   = cur[c].bypass ? cur[c].d : low[c];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Next state and control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step == LastStep) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign stat.busy = (state != BK_IDLE);
  assign stat.done = (state == BK_DONE);

  // Step counter
  always_ff @(posedge clk) begin
    if (rst)                  step <= '0;
    else if (pop)             step <= '0;
    else if (state == BK_DIV) step <= step + 1'b1;
  end

  // Load a job, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= jobs;
      for (int c = 0; c < 3; c++) begin
        rem[c] <= num[c][15:8];
        low[c] <= num[c][7:0];
      end
    end else if (state == BK_DIV) begin
      for (int c = 0; c < 3; c++) begin
        rem[c] <= ge[c] ? 8'(trial[c] - {1'b0, cur[c].span}) : trial[c][7:0];
        low[c] <= {low[c][6:0], ge[c]};
      end
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (out_load)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_pix <= {res[2], res[1], res[0]};
  end

endmodule

/* design/rgb_min_max_contrast_stretch.sv */
// Per-channel min-max contrast stretch for 8-bit RGB pixels. Each input
// transaction is a measure pixel (tuser[0] = 0) that updates the running
// min/max of red, green and blue, restarting them when tuser[1] is set, or an
// apply pixel (tuser[0] = 1) that yields one output transaction with each
// channel set to floor(255*(v-min)/(max-min)), with v clamped to min..max, or
// passed unchanged when max <= min. Input is accepted while the job queue is
// not full; an apply pixel goes into a QUEUE_DEPTH-entry job queue, and the
// back end takes one job at a time through load, the per-channel bit-serial
// divider and output register, taking no new job until the last is loaded.
// Output order equals input order of apply pixels.
// Depends on rgbmm_pkg, rgbmm_front, rgbmm_queue and rgbmm_back.
module rgb_min_max_contrast_stretch #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  input  logic [1:0]  s_axis_tuser,   // [0] cmd, [1] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
);
  import rgbmm_pkg::*;

  logic     push;
  logic     pop;
  job_t     push_job;
  job_t     pop_job;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;
  logic     s_accept;

  assign s_accept = s_axis_tvalid && s_axis_tready;

  rgbmm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser[0]),
    .in_start (s_axis_tuser[1]),
    .in_pix   (s_axis_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  rgbmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  rgbmm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_job     (pop_job),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pix   (m_axis_tdata),
    .stat      (bk_stat)
  );

  // Queue cannot be empty and full at once
  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.empty && q_stat.full))
    else $error("queue reports empty and full together");

  // Measure pixels never enter the queue
  a_measure_no_push: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (cmd_t'(s_axis_tuser[0]) == CMD_MEASURE)) |-> !push)
    else $error("measure pixel pushed a job");

  // Back end pops only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Back end takes a new job only while idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> !bk_stat.busy)
    else $error("pop while a division is in progress");

  // A new result appears only after a finished division
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(bk_stat.done))
    else $error("output valid without a finished division");

endmodule

/* sim/rgbmm_checker.sv */
`timescale 1ns / 1ps
// Stream checker for rgb_min_max_contrast_stretch: tracks per-channel min/max
// from measure transactions and compares every output pixel against its prediction.
// Depends on rgbmm_pkg for the pixel and command types.
module rgbmm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  input  logic [1:0]  s_tuser,   // [0] cmd, [1] frame_start
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output int          fail_count,
  output int          pending,
  output int          measure_count,
  output int          result_count
);
  import rgbmm_pkg::*;

  typedef struct {
    pix_t chan [3];
  } rgb_pixel_t;

  // Running statistics, index 0 red, 1 green, 2 blue
  pix_t chan_low  [3];
  pix_t chan_high [3];
  rgb_pixel_t stretched_pixels [$];

  string chan_name [3] = '{"red", "green", "blue"};

  // Scale one channel into 0..255 over the measured range
  function automatic pix_t stretch_chan(pix_t v, pix_t lo, pix_t hi);
    pix_t        x;
    logic [15:0] num;
    if (hi <= lo) begin
      return v;
    end
    x = v;
    if (x < lo) begin
      x = lo;
    end
    if (x > hi) begin
      x = hi;
    end
    num = 16'(x - lo) * 16'd255;
    return pix_t'(num / 16'(hi - lo));
  endfunction

  always @(posedge clk) begin
    rgb_pixel_t in_pix;
    rgb_pixel_t want;
    pix_t       got;
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        chan_low[c]  = 8'd255;
        chan_high[c] = 8'd0;
      end
      stretched_pixels.delete();
      fail_count    = 0;
      measure_count = 0;
      result_count  = 0;
    end else begin
      // Predict on each accepted input transaction
      if (s_tvalid && s_tready) begin
        for (int c = 0; c < 3; c++) begin
          in_pix.chan[c] = s_tdata[8*c +: 8];
        end
        if (cmd_t'(s_tuser[0]) == CMD_MEASURE) begin
          measure_count++;
          for (int c = 0; c < 3; c++) begin
            if (s_tuser[1]) begin
              chan_low[c]  = in_pix.chan[c];
              chan_high[c] = in_pix.chan[c];
            end else begin
              if (in_pix.chan[c] < chan_low[c]) chan_low[c] = in_pix.chan[c];
              if (in_pix.chan[c] > chan_high[c]) chan_high[c] = in_pix.chan[c];
            end
          end
        end else begin
          for (int c = 0; c < 3; c++) begin
            want.chan[c] = stretch_chan(in_pix.chan[c], chan_low[c], chan_high[c]);
          end
          stretched_pixels.push_back(want);
        end
      end
      // Compare each accepted output transaction with the oldest prediction
      if (m_tvalid && m_tready) begin
        result_count++;
        if (stretched_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] unexpected output pixel %06h", $realtime, m_tdata);
          end
        end else begin
          want = stretched_pixels.pop_front();
          for (int c = 0; c < 3; c++) begin
            got = m_tdata[8*c +: 8];
            if (got !== want.chan[c]) begin
              fail_count++;
              if (fail_count <= 10) begin
                $display("[%0t] result %0d %s: expected %0d, got %0d", $realtime,
                         result_count, chan_name[c], want.chan[c], got);
              end
            end
          end
        end
      end
      pending = stretched_pixels.size();
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for rgb_min_max_contrast_stretch: clock, reset, pixel stimulus
// and verdict. Depends on rgbmm_pkg, rgbmm_checker and the block itself.
module tb_top;
  import rgbmm_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int TailCycles = 40;
  localparam int HoldCycles = 200;
  localparam int PhaseItems = 155;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int fail_count;
  int pending;
  int measure_count;
  int result_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int items_sent     = 0;

  int idle_mix [4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{33, 33}};

  rgb_min_max_contrast_stretch dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rgbmm_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_axis_tvalid),
    .s_tready      (s_axis_tready),
    .s_tdata       (s_axis_tdata),
    .s_tuser       (s_axis_tuser),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .measure_count (measure_count),
    .result_count  (result_count)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("** rgb_min_max_contrast_stretch: FAILED **");
      $finish;
    end
  end

  // Output side: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one pixel and hold it until the block takes it
  task automatic send_pixel(input cmd_t cmd, input logic restart,
                            input pix_t r, input pix_t g, input pix_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 24'($urandom);
      s_axis_tuser  = 2'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b, g, r};
    s_axis_tuser  = {restart, cmd};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stop offering and wait until every stretched pixel has come out
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly inside the measured range, sometimes anywhere
  function automatic pix_t pick_chan(pix_t lo, pix_t hi);
    if ($urandom_range(3) == 0) begin
      return pix_t'($urandom_range(255));
    end
    return pix_t'($urandom_range(hi, lo));
  endfunction

  // Measure-then-apply frames with random ranges, plus some noise
  task automatic run_frames(input int target);
    pix_t lo [3];
    pix_t hi [3];
    pix_t a;
    pix_t b;
    logic restart_frame;
    int   n_meas;
    int   n_apply;
    while (items_sent < target) begin
      if ($urandom_range(9) == 0) begin
        repeat (3) begin
          send_pixel(cmd_t'($urandom_range(1)), 1'($urandom_range(1)),
                     pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
        end
      end else begin
        for (int c = 0; c < 3; c++) begin
          a = pix_t'($urandom_range(255));
          b = pix_t'($urandom_range(255));
          lo[c] = (a < b) ? a : b;
          hi[c] = (a < b) ? b : a;
          if ($urandom_range(7) == 0) hi[c] = lo[c];
        end
        restart_frame = ($urandom_range(9) != 0);
        n_meas  = $urandom_range(8, 1);
        n_apply = $urandom_range(10, 1);
        for (int i = 0; i < n_meas; i++) begin
          send_pixel(CMD_MEASURE, restart_frame && (i == 0),
                     pix_t'($urandom_range(hi[0], lo[0])),
                     pix_t'($urandom_range(hi[1], lo[1])),
                     pix_t'($urandom_range(hi[2], lo[2])));
        end
        for (int i = 0; i < n_apply; i++) begin
          send_pixel(CMD_APPLY, 1'($urandom_range(1)), pick_chan(lo[0], hi[0]),
                     pick_chan(lo[1], hi[1]), pick_chan(lo[2], hi[2]));
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Apply before any measure: ranges are empty, channels pass unchanged
    send_pixel(CMD_APPLY, 1'b0, 8'd0, 8'd128, 8'd255);
    send_pixel(CMD_APPLY, 1'b0, 8'd255, 8'd0, 8'd1);
    // Red 10..200, green flat at 20, blue 30..100
    send_pixel(CMD_MEASURE, 1'b1, 8'd10, 8'd20, 8'd30);
    send_pixel(CMD_MEASURE, 1'b0, 8'd200, 8'd20, 8'd100);
    send_pixel(CMD_APPLY, 1'b0, 8'd10, 8'd20, 8'd30);
    send_pixel(CMD_APPLY, 1'b0, 8'd200, 8'd21, 8'd100);
    // Values below low and above high saturate
    send_pixel(CMD_APPLY, 1'b0, 8'd5, 8'd0, 8'd255);
    send_pixel(CMD_APPLY, 1'b0, 8'd105, 8'd255, 8'd65);
    // frame_start on an apply pixel must not touch the statistics
    send_pixel(CMD_APPLY, 1'b1, 8'd105, 8'd19, 8'd64);
    // Full range
    send_pixel(CMD_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(CMD_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(CMD_APPLY, 1'b0, 8'd0, 8'd255, 8'd128);
    send_pixel(CMD_APPLY, 1'b0, 8'd255, 8'd0, 8'd1);
    // Measure without restart keeps the old range
    send_pixel(CMD_MEASURE, 1'b0, 8'd128, 8'd128, 8'd128);
    send_pixel(CMD_APPLY, 1'b0, 8'd127, 8'd1, 8'd254);
    // Narrow ranges: red 40..50, green 60..80, blue flat at 70
    send_pixel(CMD_MEASURE, 1'b1, 8'd50, 8'd60, 8'd70);
    send_pixel(CMD_MEASURE, 1'b0, 8'd40, 8'd80, 8'd70);
    send_pixel(CMD_APPLY, 1'b0, 8'd45, 8'd70, 8'd69);
    send_pixel(CMD_APPLY, 1'b0, 8'd255, 8'd59, 8'd255);
    drain();

    // Random frames under each idle mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      run_frames(items_sent + PhaseItems);
      drain();
    end

    // Long output hold-off while apply pixels keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pixel(CMD_MEASURE, 1'b1, pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
    hold_req = 1'b1;
    repeat (12) begin
      send_pixel(CMD_APPLY, 1'b0, pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
    end
    drain();

    repeat (TailCycles) @(negedge clk);
    $display("Sent %0d pixels: %0d measure, %0d stretched results checked,", items_sent,
             measure_count, result_count);
    $display("over four idle/stall mixes and a %0d-cycle output hold-off.", HoldCycles);
    if (fail_count == 0) begin
      $display("** rgb_min_max_contrast_stretch: PASSED **");
    end else begin
      $display("** rgb_min_max_contrast_stretch: FAILED **");
    end
    $finish;
  end

endmodule
